@@ design/chsu_pkg.sv @@
// Package for the convex hull stack update block: sizes, codes, item types.
`default_nettype none
package chsu_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int COORD_BITS  = 24;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int IDX_W       = 10;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_PUSH,
    ST_RDAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                   func;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [IDX_W-1:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        hull_count;
    logic [CNT_W-1:0]        pops_done;
    logic signed [COORD_BITS-1:0] read_x;
    logic signed [COORD_BITS-1:0] read_y;
    logic                    overflow;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/convex_hull_stack_update.sv @@
// Top level of the convex hull stack update block.
// Keeps a stack of hull points in one RAM (x and y side by side) with the top point
// also held in registers. An update item pops while the second-to-top, top and new
// point fail a strict left turn, then pushes the point (dropped and flagged if full).
// A read item returns one entry, a clear item empties the stack; each item gives one
// result. An update reads the second-to-top point from RAM on acceptance; each turn
// test then forms two registered 25x25 products in ST_MUL and compares them in ST_CMP.
// A pop reads the next point down for the next test. The push is done in ST_CMP on a
// left turn, or in ST_PUSH when fewer than two points are left or were held on arrival.
// A read that hits takes its RAM data in ST_RDAT; clear, no-op and out-of-range reads go
// straight to ST_DONE, which waits while the result slot is stalled. The single RAM read
// port and the multiply-then-compare turn test shape this sequence. RAM contents are
// undefined after reset; only entries below the count are ever read, so no clearing pass is run.
`default_nettype none
module convex_hull_stack_update (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire chsu_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output chsu_pkg::out_item_t     out_data
);

  localparam int CW     = chsu_pkg::COORD_BITS;
  localparam int CNT_W  = chsu_pkg::CNT_W;
  localparam int ADDR_W = chsu_pkg::ADDR_W;
  localparam int DIFF_W = chsu_pkg::DIFF_W;
  localparam int PROD_W = chsu_pkg::PROD_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(chsu_pkg::STACK_DEPTH);

  chsu_pkg::state_t state_r, state_nxt;

  chsu_pkg::in_item_t  pt_r, pt_nxt;
  chsu_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        pops_r, pops_nxt;
  logic                    ovf_r, ovf_nxt;
  logic signed [CW-1:0]    top_x_r, top_x_nxt, top_y_r, top_y_nxt;
  logic signed [CW-1:0]    rd_x_r, rd_x_nxt, rd_y_r, rd_y_nxt;
  logic signed [PROD_W-1:0] prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [2*CW-1:0]   ram_wdata, ram_rdata;
  logic signed [CW-1:0] sec_x, sec_y;

  logic slot_free, accept, left_turn, full, cnt_ge2, cnt_ge3, idx_hit;
  logic do_pop, do_push, load_out;

  logic signed [DIFF_W-1:0] dqx, dqy, drx, dry;

  chsu_ram #(
    .WIDTH (2 * CW),
    .DEPTH (chsu_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sec_x     = $signed(ram_rdata[2*CW-1:CW]);
  assign sec_y     = $signed(ram_rdata[CW-1:0]);
  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign left_turn = prod_a_r > prod_b_r;
  assign full      = count_r == FULL_CNT;
  assign cnt_ge2   = count_r >= CNT_W'(2);
  assign cnt_ge3   = count_r >= CNT_W'(3);
  assign idx_hit   = CNT_W'(in_data.read_index) < count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chsu_pkg::ST_IDLE, chsu_pkg::ST_DONE: begin
        if (state_r == chsu_pkg::ST_DONE && slot_free) begin
          state_nxt = chsu_pkg::ST_IDLE;
        end
        if (accept) begin
          case (in_data.func)
            chsu_pkg::FUNC_UPDATE: state_nxt = cnt_ge2 ? chsu_pkg::ST_MUL : chsu_pkg::ST_PUSH;
            chsu_pkg::FUNC_READ:   state_nxt = idx_hit ? chsu_pkg::ST_RDAT : chsu_pkg::ST_DONE;
            default:               state_nxt = chsu_pkg::ST_DONE;
          endcase
        end
      end
      chsu_pkg::ST_MUL: state_nxt = chsu_pkg::ST_CMP;
      chsu_pkg::ST_CMP: begin
        if (left_turn) begin
          state_nxt = chsu_pkg::ST_DONE;
        end else begin
          state_nxt = cnt_ge3 ? chsu_pkg::ST_MUL : chsu_pkg::ST_PUSH;
        end
      end
      chsu_pkg::ST_PUSH: state_nxt = chsu_pkg::ST_DONE;
      chsu_pkg::ST_RDAT: state_nxt = chsu_pkg::ST_DONE;
      default:           state_nxt = chsu_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    load_out  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      chsu_pkg::ST_IDLE: in_ready = 1'b1;
      chsu_pkg::ST_DONE: begin
        load_out = slot_free;
        in_ready = slot_free;
      end
      chsu_pkg::ST_CMP: begin
        do_pop  = !left_turn;
        do_push = left_turn;
      end
      chsu_pkg::ST_PUSH: do_push = 1'b1;
      default: ;
    endcase
    if (in_valid && in_ready) begin
      case (in_data.func)
        chsu_pkg::FUNC_UPDATE: begin
          ram_re    = cnt_ge2;
          ram_raddr = ADDR_W'(count_r - CNT_W'(2));
        end
        chsu_pkg::FUNC_READ: begin
          ram_re    = idx_hit;
          ram_raddr = ADDR_W'(in_data.read_index);
        end
        default: ;
      endcase
    end
    if (do_pop && cnt_ge3) begin
      ram_re    = 1'b1;
      ram_raddr = ADDR_W'(count_r - CNT_W'(3));
    end
  end

  assign ram_we    = do_push && !full;
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_wdata = {pt_r.px, pt_r.py};

  // turn test operands: p = second-to-top (RAM), q = top, r = new point
  assign dqx = DIFF_W'(top_x_r) - DIFF_W'(sec_x);
  assign dqy = DIFF_W'(top_y_r) - DIFF_W'(sec_y);
  assign drx = DIFF_W'(pt_r.px) - DIFF_W'(sec_x);
  assign dry = DIFF_W'(pt_r.py) - DIFF_W'(sec_y);

  // datapath next values
  always_comb begin
    pt_nxt        = pt_r;
    count_nxt     = count_r;
    pops_nxt      = pops_r;
    ovf_nxt       = ovf_r;
    top_x_nxt     = top_x_r;
    top_y_nxt     = top_y_r;
    rd_x_nxt      = rd_x_r;
    rd_y_nxt      = rd_y_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (load_out) begin
      out_data_nxt.hull_count = count_r;
      out_data_nxt.pops_done  = pops_r;
      out_data_nxt.read_x     = rd_x_r;
      out_data_nxt.read_y     = rd_y_r;
      out_data_nxt.overflow   = ovf_r;
      out_valid_nxt           = 1'b1;
    end

    if (accept) begin
      pt_nxt   = in_data;
      pops_nxt = '0;
      ovf_nxt  = 1'b0;
      rd_x_nxt = '0;
      rd_y_nxt = '0;
      if (in_data.func == chsu_pkg::FUNC_CLEAR) begin
        count_nxt = '0;
      end
    end

    if (state_r == chsu_pkg::ST_MUL) begin
      prod_a_nxt = PROD_W'(dqx) * PROD_W'(dry);
      prod_b_nxt = PROD_W'(drx) * PROD_W'(dqy);
    end

    if (state_r == chsu_pkg::ST_RDAT) begin
      rd_x_nxt = sec_x;
      rd_y_nxt = sec_y;
    end

    if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
      pops_nxt  = pops_r + CNT_W'(1);
      top_x_nxt = sec_x;
      top_y_nxt = sec_y;
    end

    if (do_push) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        top_x_nxt = pt_r.px;
        top_y_nxt = pt_r.py;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chsu_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r       <= pt_nxt;
    pops_r     <= pops_nxt;
    ovf_r      <= ovf_nxt;
    top_x_r    <= top_x_nxt;
    top_y_r    <= top_y_nxt;
    rd_x_r     <= rd_x_nxt;
    rd_y_r     <= rd_y_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_b_r   <= prod_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ design/chsu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module chsu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/chsu_checker.sv @@
// Port-level assertion checker for the convex hull stack update block, with its bind.
`default_nettype none
module chsu_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire chsu_pkg::out_item_t out_data
);

  localparam logic [chsu_pkg::CNT_W-1:0] FULL_CNT =
    chsu_pkg::CNT_W'(chsu_pkg::STACK_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hull_count <= FULL_CNT)
    else $error("hull count beyond stack depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.hull_count == FULL_CNT)
    else $error("overflow flagged on a stack that is not full");

  a_update_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pops_done != '0 || out_data.overflow)
      |-> out_data.read_x == '0 && out_data.read_y == '0)
    else $error("update result carries read data");

endmodule

bind convex_hull_stack_update chsu_checker u_chsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/hull_sb_pkg.sv @@
// Scoreboard for the hull stack block: own copy of the stack and the expected results.
`timescale 1ns / 1ps
package hull_sb_pkg;

  class hull_scoreboard;
    logic signed [chsu_pkg::COORD_BITS-1:0] pt_x [chsu_pkg::STACK_DEPTH];
    logic signed [chsu_pkg::COORD_BITS-1:0] pt_y [chsu_pkg::STACK_DEPTH];
    int depth_used;
    chsu_pkg::out_item_t hull_results_q[$];
    int fail_count;

    function new();
      depth_used = 0;
      fail_count = 0;
    endfunction

    function bit turns_left(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
      return ((bx - ax) * (cy - ay) - (cx - ax) * (by - ay)) > 0;
    endfunction

    function void note_item(chsu_pkg::in_item_t it);
      chsu_pkg::out_item_t r;
      longint nx;
      longint ny;
      int pops;
      r = '0;
      pops = 0;
      nx = longint'(it.px);
      ny = longint'(it.py);
      case (it.func)
        chsu_pkg::FUNC_UPDATE: begin
          while (depth_used >= 2 &&
                 !turns_left(longint'(pt_x[depth_used-2]), longint'(pt_y[depth_used-2]),
                             longint'(pt_x[depth_used-1]), longint'(pt_y[depth_used-1]),
                             nx, ny)) begin
            depth_used--;
            pops++;
          end
          if (depth_used < chsu_pkg::STACK_DEPTH) begin
            pt_x[depth_used] = it.px;
            pt_y[depth_used] = it.py;
            depth_used++;
          end else begin
            r.overflow = 1'b1;
          end
          r.pops_done = chsu_pkg::CNT_W'(pops);
        end
        chsu_pkg::FUNC_READ: begin
          if (int'(it.read_index) < depth_used) begin
            r.read_x = pt_x[it.read_index];
            r.read_y = pt_y[it.read_index];
          end
        end
        chsu_pkg::FUNC_CLEAR: begin
          depth_used = 0;
        end
        default: begin
        end
      endcase
      r.hull_count = chsu_pkg::CNT_W'(depth_used);
      hull_results_q.push_back(r);
    endfunction

    function void check_field(string name, logic signed [63:0] want_v,
                              logic signed [63:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_result(chsu_pkg::out_item_t got);
      chsu_pkg::out_item_t want;
      if (hull_results_q.size() == 0) begin
        $error("result with none pending: hull_count %0d", got.hull_count);
        fail_count++;
        return;
      end
      want = hull_results_q.pop_front();
      check_field("hull_count", 64'(want.hull_count), 64'(got.hull_count));
      check_field("pops_done", 64'(want.pops_done), 64'(got.pops_done));
      check_field("read_x", 64'($signed(want.read_x)), 64'($signed(got.read_x)));
      check_field("read_y", 64'($signed(want.read_y)), 64'($signed(got.read_y)));
      check_field("overflow", 64'(want.overflow), 64'(got.overflow));
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
// Top of the hull stack testbench: clock, reset, item drivers, stimulus and end of run.
`timescale 1ns / 1ps
module tb_top;

  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int C_MIN = -8388608;
  localparam int C_MAX = 8388607;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  chsu_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  chsu_pkg::out_item_t out_data;

  hull_sb_pkg::hull_scoreboard hull_sb = new();
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  convex_hull_stack_update uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      hull_sb.check_result(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < 30) hold = pick_gap();
      end
    end
  end

  function automatic chsu_pkg::in_item_t make_item(chsu_pkg::func_t f, int x, int y,
                                                   int idx);
    chsu_pkg::in_item_t it;
    it.func = f;
    it.px = chsu_pkg::COORD_BITS'(x);
    it.py = chsu_pkg::COORD_BITS'(y);
    it.read_index = chsu_pkg::IDX_W'(idx);
    return it;
  endfunction

  task automatic send_item(input chsu_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hull_sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic do_update(int x, int y);
    send_item(make_item(chsu_pkg::FUNC_UPDATE, x, y, $urandom_range(1023)));
  endtask

  task automatic do_read(int idx);
    send_item(make_item(chsu_pkg::FUNC_READ, $urandom, $urandom, idx));
  endtask

  task automatic do_other(chsu_pkg::func_t f);
    send_item(make_item(f, $urandom, $urandom, $urandom_range(1023)));
  endtask

  // index mostly inside the hull, sometimes anywhere
  function automatic int pick_index();
    if (hull_sb.depth_used > 0 && $urandom_range(99) < 80)
      return $urandom_range(0, hull_sb.depth_used - 1);
    return $urandom_range(1023);
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (hull_sb.hull_results_q.size() != 0);
  endtask

  // points on a parabola keep turning left; broken chains add dips and repeats
  task automatic run_chain(bit broken);
    int n, x0, y0, dx, a, i, lx, ly, k;
    n  = $urandom_range(3, 30);
    x0 = $urandom_range(0, 8000000) - 4000000;
    y0 = $urandom_range(0, 8000000) - 4000000;
    dx = $urandom_range(1, 1000);
    a  = $urandom_range(1, 50);
    if ($urandom_range(1)) begin
      dx = -dx;
      a  = -a;
    end
    for (i = 0; i < n; i++) begin
      lx = x0 + i * dx;
      ly = y0 + a * i * i;
      k  = $urandom_range(99);
      if (broken && k < 10) begin
        do_update(lx, ly);
        do_update(lx, ly);
      end else if (broken && k < 25) begin
        do_update(lx, ly - a * $urandom_range(1, 400));
      end else begin
        do_update(lx, ly);
      end
      if ($urandom_range(99) < 10) do_read(pick_index());
    end
  endtask

  task automatic fill_stack();
    int i;
    do_other(chsu_pkg::FUNC_CLEAR);
    for (i = 0; i < chsu_pkg::STACK_DEPTH + 3; i++) begin
      do_update(C_MIN + i * 8000, C_MIN + 7 * i * i);
    end
    do_read(0);
    do_read(511);
    do_read(1023);
    do_update(C_MAX, C_MIN);
    do_read(1);
  endtask

  initial begin : stimulus
    int pick, n, i;
    bit filled;
    filled = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    do_read(0);
    do_read(1023);
    do_other(chsu_pkg::FUNC_NOP);
    do_other(chsu_pkg::FUNC_CLEAR);
    do_update(C_MIN, C_MIN);
    do_update(C_MIN, C_MIN);
    do_update(C_MAX, C_MAX);
    do_update(C_MAX, C_MAX);
    do_update(C_MAX, C_MIN);
    do_update(C_MIN, C_MAX);
    do_read(0);
    do_read(1);
    do_read(2);
    do_read(1023);
    do_other(chsu_pkg::FUNC_CLEAR);
    do_read(0);
    do_update(0, 0);
    do_update(1, 1);
    do_update(2, 2);
    do_update(3, 1);
    do_update(2, 5);
    do_other(chsu_pkg::FUNC_NOP);
    do_read(1);
    drain();

    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(99) < 15);
      pick = $urandom_range(99);
      if (!filled && items_sent > 300) begin
        drain();
        fill_stack();
        filled = 1'b1;
      end else if (pick < 40) begin
        run_chain(1'b0);
      end else if (pick < 52) begin
        run_chain(1'b1);
      end else if (pick < 62) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0)
            do_update($urandom_range(1) ? C_MAX : C_MIN, $urandom_range(1) ? C_MAX : C_MIN);
          else
            do_update($urandom, $urandom);
        end
      end else if (pick < 72) begin
        n = $urandom_range(4, 20);
        for (i = 0; i < n; i++) begin
          do_update($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
        end
      end else if (pick < 87) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) do_read(pick_index());
      end else if (pick < 93) begin
        do_other(chsu_pkg::FUNC_CLEAR);
      end else if (pick < 97) begin
        do_other(chsu_pkg::FUNC_NOP);
      end else begin
        drain();
      end
    end

    calm = 1'b0;
    drain();
    repeat (40) @(negedge clk);
    if (hull_sb.hull_results_q.size() != 0) begin
      $error("%0d expected results never arrived", hull_sb.hull_results_q.size());
      hull_sb.fail_count++;
    end
    if (hull_sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
